// ----- rtl/core/rpsc_pkg.sv -----
// ----------------------------------------------------------------------------
// rpsc_pkg: shared types and constants of the ramped PI speed controller
// Field widths, stream packing, register indexes, tick kinds, saturation.
// ----------------------------------------------------------------------------
package rpsc_pkg;

    localparam int MOTOR_W         = 3;
    localparam int MOTOR_COUNT_DEF = 8;
    localparam int RPM_W           = 14;
    localparam int DUTY_W          = 16;
    localparam int VAL_W           = 16;
    localparam int INTEG_W         = 32;
    localparam int GAIN_W          = 8;
    localparam int STEP_W          = 10;
    localparam int LEVEL_W         = 14;
    localparam int LIMIT_W         = 8;
    localparam int QUEUE_DEPTH     = 4;

    // product and sum widths of the PI terms
    localparam int PTERM_W = GAIN_W + 1 + VAL_W;
    localparam int ITERM_W = GAIN_W + 1 + INTEG_W;
    localparam int PI_W    = ITERM_W + 1;

    // configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    // input tdata: motor, run, set_rpm, measured_rpm, duty_offset
    localparam int IN_RUN_LSB  = MOTOR_W;
    localparam int IN_SET_LSB  = IN_RUN_LSB + 1;
    localparam int IN_MEAS_LSB = IN_SET_LSB + RPM_W;
    localparam int IN_OFF_LSB  = IN_MEAS_LSB + RPM_W;
    localparam int S_TDATA_W   = 48;

    // output tdata: motor_out, duty, ramp_target, speed_error, fault
    localparam int OUT_FIELDS_W = MOTOR_W + DUTY_W + 2 * VAL_W + 1;
    localparam int M_TDATA_W    = 56;

    // register reset values
    localparam logic [GAIN_W-1:0]  PROP_GAIN_RST   = GAIN_W'(1);
    localparam logic [GAIN_W-1:0]  INTEG_GAIN_RST  = GAIN_W'(0);
    localparam logic [STEP_W-1:0]  RAMP_STEP_RST   = STEP_W'(5);
    localparam logic [DUTY_W-1:0]  MAX_DUTY_RST    = DUTY_W'(4095);
    localparam logic [LEVEL_W-1:0] FAULT_LEVEL_RST = LEVEL_W'(400);
    localparam logic [LIMIT_W-1:0] FAULT_LIMIT_RST = LIMIT_W'(10);

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_PROP_GAIN   = 3'd0,
        REG_INTEG_GAIN  = 3'd1,
        REG_RAMP_STEP   = 3'd2,
        REG_MAX_DUTY    = 3'd3,
        REG_FAULT_LEVEL = 3'd4,
        REG_FAULT_LIMIT = 3'd5
    } t_reg_idx;

    typedef enum logic [1:0] {
        KIND_STEP  = 2'd0,  // normal control step
        KIND_CLEAR = 2'd1,  // per-motor reset
        KIND_SKIP  = 2'd2   // motor index out of range
    } t_kind;

    typedef struct packed {
        logic [GAIN_W-1:0]  prop_gain;
        logic [GAIN_W-1:0]  integ_gain;
        logic [STEP_W-1:0]  ramp_step;
        logic [DUTY_W-1:0]  max_duty;
        logic [LEVEL_W-1:0] fault_level;
        logic [LIMIT_W-1:0] fault_limit;
    } t_cfg;

    typedef struct packed {
        t_kind              kind;
        logic [MOTOR_W-1:0] motor;
        logic               run;
        logic [RPM_W-1:0]   set_rpm;
        logic [RPM_W-1:0]   meas_rpm;
        logic [DUTY_W-1:0]  offset;
    } t_tick;

    function automatic logic signed [VAL_W-1:0] sat16(input logic signed [VAL_W:0] v);
        logic signed [VAL_W-1:0] r;
        if (v > $signed({2'b00, {(VAL_W-1){1'b1}}})) begin
            r = {1'b0, {(VAL_W-1){1'b1}}};
        end else if (v < $signed({2'b11, {(VAL_W-1){1'b0}}})) begin
            r = {1'b1, {(VAL_W-1){1'b0}}};
        end else begin
            r = v[VAL_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [INTEG_W-1:0] sat32(input logic signed [INTEG_W:0] v);
        logic signed [INTEG_W-1:0] r;
        if (v[INTEG_W] != v[INTEG_W-1]) begin
            r = {v[INTEG_W], {(INTEG_W-1){~v[INTEG_W]}}};
        end else begin
            r = v[INTEG_W-1:0];
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/rpsc_front.sv -----
// ----------------------------------------------------------------------------
// rpsc_front: tick intake
// Takes control ticks off the input stream, unpacks and classifies them
// (step, clear, out-of-range) and holds one tick for the queue.
// ----------------------------------------------------------------------------
module rpsc_front #(
    parameter int MOTOR_COUNT = rpsc_pkg::MOTOR_COUNT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [rpsc_pkg::S_TDATA_W-1:0] i_data,
    input  logic                           i_clear,
    output logic                           o_valid,
    input  logic                           i_ready,
    output rpsc_pkg::t_tick                o_tick
);
    import rpsc_pkg::*;

    logic  r_valid;
    t_tick r_tick;
    t_tick n_tick;

    always_comb begin
        n_tick.motor    = i_data[MOTOR_W-1:0];
        n_tick.run      = i_data[IN_RUN_LSB];
        n_tick.set_rpm  = i_data[IN_SET_LSB +: RPM_W];
        n_tick.meas_rpm = i_data[IN_MEAS_LSB +: RPM_W];
        n_tick.offset   = i_data[IN_OFF_LSB +: DUTY_W];
        if (int'(n_tick.motor) >= MOTOR_COUNT) begin
            n_tick.kind = KIND_SKIP;
        end else if (i_clear) begin
            n_tick.kind = KIND_CLEAR;
        end else begin
            n_tick.kind = KIND_STEP;
        end
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_tick  = r_tick;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_tick <= n_tick;
        end
    end

endmodule

// ----- rtl/core/rpsc_queue.sv -----
// ----------------------------------------------------------------------------
// rpsc_queue: tick queue
// Short FIFO between intake and the control pipeline; head is read directly.
// ----------------------------------------------------------------------------
module rpsc_queue #(
    parameter int DEPTH = rpsc_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    output logic            o_ready,
    input  rpsc_pkg::t_tick i_tick,
    output logic            o_valid,
    input  logic            i_pop,
    output rpsc_pkg::t_tick o_tick
);
    import rpsc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_tick              r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr;
    logic [PTR_W-1:0]   r_rd;
    logic [CNT_W-1:0]   r_count;
    logic               push_ok;
    logic               pop_ok;

    assign o_ready = (r_count != CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign push_ok = i_push && o_ready;
    assign pop_ok  = i_pop && o_valid;
    assign o_tick  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push_ok) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop_ok) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({push_ok, pop_ok})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= i_tick;
        end
    end

endmodule

// ----- rtl/core/rpsc_back.sv -----
// ----------------------------------------------------------------------------
// rpsc_back: PI control pipeline
// Ramp (A), error (B), fault count and integral (C), gain products (D),
// PI sum (E), duty decision into the output register. Each per-motor store
// is read and written in one stage only, so ticks follow back to back.
// ----------------------------------------------------------------------------
module rpsc_back #(
    parameter int MOTOR_COUNT = rpsc_pkg::MOTOR_COUNT_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  rpsc_pkg::t_cfg                      i_cfg,
    input  logic                                i_valid,
    output logic                                o_pop,
    input  rpsc_pkg::t_tick                     i_tick,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [rpsc_pkg::MOTOR_W-1:0]        o_motor,
    output logic [rpsc_pkg::DUTY_W-1:0]         o_duty,
    output logic signed [rpsc_pkg::VAL_W-1:0]   o_target,
    output logic signed [rpsc_pkg::VAL_W-1:0]   o_error,
    output logic                                o_fault
);
    import rpsc_pkg::*;

    localparam int SPAN  = 2 ** MOTOR_W;
    localparam int DEPTH = (MOTOR_COUNT < SPAN) ? MOTOR_COUNT : SPAN;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // per-motor state
    logic signed [VAL_W-1:0]   r_target [DEPTH];
    logic signed [INTEG_W-1:0] r_integ  [DEPTH];
    logic        [DUTY_W-1:0]  r_duty   [DEPTH];
    logic        [LIMIT_W-1:0] r_bad_cnt;
    logic                      r_fault;

    logic en;
    assign en    = !o_valid || i_ready;
    assign o_pop = en;

    // ---------------- stage A: ramp ----------------
    logic [IDX_W-1:0]        a_idx;
    logic signed [VAL_W-1:0] a_old;
    logic signed [VAL_W:0]   a_old17;
    logic signed [VAL_W:0]   a_set17;
    logic signed [VAL_W:0]   a_up17;
    logic signed [VAL_W:0]   a_dn17;
    logic signed [VAL_W-1:0] a_new;

    logic                    r_a_valid;
    t_kind                   r_a_kind;
    logic [MOTOR_W-1:0]      r_a_motor;
    logic signed [VAL_W-1:0] r_a_tgt;
    logic [RPM_W-1:0]        r_a_meas;
    logic [DUTY_W-1:0]       r_a_offset;

    always_comb begin
        a_idx   = i_tick.motor[IDX_W-1:0];
        a_old   = r_target[a_idx];
        a_old17 = {a_old[VAL_W-1], a_old};
        a_set17 = $signed({{(VAL_W + 1 - RPM_W){1'b0}}, i_tick.set_rpm});
        a_up17  = a_old17 + $signed({{(VAL_W + 1 - STEP_W){1'b0}}, i_cfg.ramp_step});
        a_dn17  = a_old17 - $signed({{(VAL_W + 1 - STEP_W){1'b0}}, i_cfg.ramp_step});
        case (i_tick.kind)
            KIND_STEP: begin
                if (i_tick.run) begin
                    // a step up that overshoots is stepped back down to the old target
                    if (a_old17 <= a_set17) begin
                        a_new = (a_up17 > a_set17) ? a_old : a_up17[VAL_W-1:0];
                    end else begin
                        a_new = sat16(a_dn17);
                    end
                end else begin
                    a_new = (a_old17 > 0) ? sat16(a_dn17) : a_old;
                end
            end
            default: a_new = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DEPTH; k++) begin
                r_target[k] <= '0;
            end
        end else if (en && i_valid && i_tick.kind != KIND_SKIP) begin
            r_target[a_idx] <= a_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_kind   <= i_tick.kind;
            r_a_motor  <= i_tick.motor;
            r_a_tgt    <= a_new;
            r_a_meas   <= i_tick.meas_rpm;
            r_a_offset <= i_tick.offset;
        end
    end

    // ---------------- stage B: error ----------------
    logic signed [VAL_W:0]   b_err17;
    logic                    r_b_valid;
    t_kind                   r_b_kind;
    logic [MOTOR_W-1:0]      r_b_motor;
    logic signed [VAL_W-1:0] r_b_tgt;
    logic signed [VAL_W-1:0] r_b_err;
    logic [DUTY_W-1:0]       r_b_offset;

    assign b_err17 = {r_a_tgt[VAL_W-1], r_a_tgt}
                   - $signed({{(VAL_W + 1 - RPM_W){1'b0}}, r_a_meas});

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_kind   <= r_a_kind;
            r_b_motor  <= r_a_motor;
            r_b_tgt    <= r_a_tgt;
            r_b_err    <= (r_a_kind == KIND_STEP) ? sat16(b_err17) : '0;
            r_b_offset <= r_a_offset;
        end
    end

    // ---------------- stage C: fault count, integral ----------------
    logic [IDX_W-1:0]          c_idx;
    logic [VAL_W:0]            c_mag;
    logic                      c_bad;
    logic [LIMIT_W-1:0]        c_cnt_inc;
    logic [LIMIT_W-1:0]        n_bad_cnt;
    logic                      n_fault;
    logic signed [INTEG_W:0]   c_sum33;
    logic signed [INTEG_W-1:0] c_new;

    logic                      r_c_valid;
    t_kind                     r_c_kind;
    logic [MOTOR_W-1:0]        r_c_motor;
    logic signed [VAL_W-1:0]   r_c_tgt;
    logic signed [VAL_W-1:0]   r_c_err;
    logic signed [INTEG_W-1:0] r_c_integ;
    logic [DUTY_W-1:0]         r_c_offset;
    logic                      r_c_fault;

    always_comb begin
        c_idx     = r_b_motor[IDX_W-1:0];
        c_mag     = r_b_err[VAL_W-1] ? -{r_b_err[VAL_W-1], r_b_err} : {1'b0, r_b_err};
        c_bad     = r_b_valid && (r_b_kind == KIND_STEP)
                 && (c_mag >= {{(VAL_W + 1 - LEVEL_W){1'b0}}, i_cfg.fault_level});
        c_cnt_inc = r_bad_cnt + 1'b1;
        n_bad_cnt = r_bad_cnt;
        n_fault   = r_fault;
        if (c_bad) begin
            if (c_cnt_inc >= i_cfg.fault_limit) begin
                n_fault   = 1'b1;
                n_bad_cnt = '0;
            end else begin
                n_bad_cnt = c_cnt_inc;
            end
        end
        c_sum33 = {r_integ[c_idx][INTEG_W-1], r_integ[c_idx]}
                + {{(INTEG_W + 1 - VAL_W){r_b_err[VAL_W-1]}}, r_b_err};
        c_new   = (r_b_kind == KIND_STEP) ? sat32(c_sum33) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bad_cnt <= '0;
            r_fault   <= 1'b0;
            for (int k = 0; k < DEPTH; k++) begin
                r_integ[k] <= '0;
            end
        end else if (en) begin
            r_bad_cnt <= n_bad_cnt;
            r_fault   <= n_fault;
            if (r_b_valid && r_b_kind != KIND_SKIP) begin
                r_integ[c_idx] <= c_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_kind   <= r_b_kind;
            r_c_motor  <= r_b_motor;
            r_c_tgt    <= r_b_tgt;
            r_c_err    <= r_b_err;
            r_c_integ  <= c_new;
            r_c_offset <= r_b_offset;
            r_c_fault  <= n_fault;
        end
    end

    // ---------------- stage D: gain products ----------------
    logic                      r_d_valid;
    t_kind                     r_d_kind;
    logic [MOTOR_W-1:0]        r_d_motor;
    logic signed [VAL_W-1:0]   r_d_tgt;
    logic signed [VAL_W-1:0]   r_d_err;
    logic signed [PTERM_W-1:0] r_d_pterm;
    logic signed [ITERM_W-1:0] r_d_iterm;
    logic [DUTY_W-1:0]         r_d_offset;
    logic                      r_d_fault;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_kind   <= r_c_kind;
            r_d_motor  <= r_c_motor;
            r_d_tgt    <= r_c_tgt;
            r_d_err    <= r_c_err;
            r_d_pterm  <= $signed({1'b0, i_cfg.prop_gain}) * r_c_err;
            r_d_iterm  <= $signed({1'b0, i_cfg.integ_gain}) * r_c_integ;
            r_d_offset <= r_c_offset;
            r_d_fault  <= r_c_fault;
        end
    end

    // ---------------- stage E: PI sum ----------------
    logic                    r_e_valid;
    t_kind                   r_e_kind;
    logic [MOTOR_W-1:0]      r_e_motor;
    logic signed [VAL_W-1:0] r_e_tgt;
    logic signed [VAL_W-1:0] r_e_err;
    logic signed [PI_W-1:0]  r_e_pi;
    logic [DUTY_W-1:0]       r_e_offset;
    logic                    r_e_fault;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e_kind   <= r_d_kind;
            r_e_motor  <= r_d_motor;
            r_e_tgt    <= r_d_tgt;
            r_e_err    <= r_d_err;
            r_e_pi     <= {{(PI_W - PTERM_W){r_d_pterm[PTERM_W-1]}}, r_d_pterm}
                        + {{(PI_W - ITERM_W){r_d_iterm[ITERM_W-1]}}, r_d_iterm};
            r_e_offset <= r_d_offset;
            r_e_fault  <= r_d_fault;
        end
    end

    // ---------------- duty decision, output register ----------------
    logic [IDX_W-1:0]       f_idx;
    logic signed [PI_W-1:0] f_sum;
    logic                   f_le_off;
    logic                   f_le_max;
    logic [DUTY_W-1:0]      f_held;
    logic [DUTY_W-1:0]      f_duty;

    logic                    r_out_valid;
    t_kind                   r_out_kind;
    logic [MOTOR_W-1:0]      r_out_motor;
    logic [DUTY_W-1:0]       r_out_duty;
    logic signed [VAL_W-1:0] r_out_tgt;
    logic signed [VAL_W-1:0] r_out_err;
    logic                    r_out_fault;

    always_comb begin
        f_idx    = r_e_motor[IDX_W-1:0];
        f_held   = r_duty[f_idx];
        f_sum    = r_e_pi + $signed({{(PI_W - DUTY_W){1'b0}}, r_e_offset});
        // sum <= offset is the same as the PI part being <= 0
        f_le_off = (r_e_pi <= 0);
        f_le_max = (f_sum <= $signed({{(PI_W - DUTY_W){1'b0}}, i_cfg.max_duty}));
        case (r_e_kind)
            KIND_STEP: begin
                if (f_le_off) begin
                    f_duty = r_e_offset;
                end else if (f_le_max) begin
                    f_duty = f_sum[DUTY_W-1:0];
                end else begin
                    f_duty = f_held;
                end
            end
            KIND_CLEAR: f_duty = f_held;
            default:    f_duty = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DEPTH; k++) begin
                r_duty[k] <= '0;
            end
        end else if (en && r_e_valid && r_e_kind == KIND_STEP) begin
            r_duty[f_idx] <= f_duty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_kind  <= r_e_kind;
            r_out_motor <= r_e_motor;
            r_out_duty  <= f_duty;
            r_out_tgt   <= r_e_tgt;
            r_out_err   <= r_e_err;
            r_out_fault <= r_e_fault;
        end
    end

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_c_valid   <= 1'b0;
            r_d_valid   <= 1'b0;
            r_e_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_a_valid   <= i_valid;
            r_b_valid   <= r_a_valid;
            r_c_valid   <= r_b_valid;
            r_d_valid   <= r_c_valid;
            r_e_valid   <= r_d_valid;
            r_out_valid <= r_e_valid;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_motor  = r_out_motor;
    assign o_duty   = r_out_duty;
    assign o_target = r_out_tgt;
    assign o_error  = r_out_err;
    assign o_fault  = r_out_fault;

`ifndef NO_ASSERTIONS
    a_fault_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fault |=> r_fault)
        else $error("fault latch dropped without reset");

    a_stall_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable({r_a_valid, r_b_valid, r_c_valid, r_d_valid, r_e_valid}))
        else $error("pipeline moved while output stalled");

    a_nonstep_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind != KIND_STEP) |-> (r_out_tgt == '0 && r_out_err == '0))
        else $error("clear or skipped tick carries nonzero target or error");

    a_skip_duty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind == KIND_SKIP) |-> (r_out_duty == '0))
        else $error("out-of-range tick carries a duty");
`endif

endmodule

// ----- rtl/core/ramped_pi_motor_speed_controller.sv -----
// ----------------------------------------------------------------------------
// ramped_pi_motor_speed_controller: per-motor PI speed loop with setpoint ramp
//
//  channel  direction  handshake            payload
//  s_*      in         s_tvalid / s_tready  s_tdata: tick fields, s_tuser: clear
//  m_*      out        m_tvalid / m_tready  m_tdata: duty result of the tick
//  i_cfg_*  in         i_cfg_we             i_cfg_addr, i_cfg_wdata
//
// One tick per cycle while the output is not stalled; an input tick passes the
// intake register, queue, five pipeline stages and output register in turn.
// Per-motor state is read-modify-written inside single stages, so ticks of the
// same motor may follow each other directly.
// Synchronous reset clears all motor state and the fault counter, presets registers.
// An output stall freezes the pipeline; the queue absorbs ticks meanwhile.
// ----------------------------------------------------------------------------
module ramped_pi_motor_speed_controller #(
    parameter int MOTOR_COUNT = rpsc_pkg::MOTOR_COUNT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [2:0] motor, [3] run, [17:4] set_rpm, [31:18] measured_rpm,
    // [47:32] duty_offset
    input  logic [rpsc_pkg::S_TDATA_W-1:0]  s_tdata,
    // [0] clear
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [2:0] motor_out, [18:3] duty, [34:19] ramp_target, [50:35] speed_error,
    // [51] fault, [55:52] zero
    output logic [rpsc_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                            i_cfg_we,
    input  logic [rpsc_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [rpsc_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import rpsc_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prop_gain   <= PROP_GAIN_RST;
            r_cfg.integ_gain  <= INTEG_GAIN_RST;
            r_cfg.ramp_step   <= RAMP_STEP_RST;
            r_cfg.max_duty    <= MAX_DUTY_RST;
            r_cfg.fault_level <= FAULT_LEVEL_RST;
            r_cfg.fault_limit <= FAULT_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_PROP_GAIN:   r_cfg.prop_gain   <= i_cfg_wdata[GAIN_W-1:0];
                REG_INTEG_GAIN:  r_cfg.integ_gain  <= i_cfg_wdata[GAIN_W-1:0];
                REG_RAMP_STEP:   r_cfg.ramp_step   <= i_cfg_wdata[STEP_W-1:0];
                REG_MAX_DUTY:    r_cfg.max_duty    <= i_cfg_wdata[DUTY_W-1:0];
                REG_FAULT_LEVEL: r_cfg.fault_level <= i_cfg_wdata[LEVEL_W-1:0];
                REG_FAULT_LIMIT: r_cfg.fault_limit <= i_cfg_wdata[LIMIT_W-1:0];
                default:         r_cfg             <= r_cfg;
            endcase
        end
    end

    logic  fq_valid;
    logic  fq_ready;
    t_tick fq_tick;
    logic  qb_valid;
    logic  qb_pop;
    t_tick qb_tick;

    logic [MOTOR_W-1:0]      res_motor;
    logic [DUTY_W-1:0]       res_duty;
    logic signed [VAL_W-1:0] res_target;
    logic signed [VAL_W-1:0] res_error;
    logic                    res_fault;

    rpsc_front #(
        .MOTOR_COUNT (MOTOR_COUNT)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_tvalid),
        .o_ready (s_tready),
        .i_data  (s_tdata),
        .i_clear (s_tuser),
        .o_valid (fq_valid),
        .i_ready (fq_ready),
        .o_tick  (fq_tick)
    );

    rpsc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fq_valid),
        .o_ready (fq_ready),
        .i_tick  (fq_tick),
        .o_valid (qb_valid),
        .i_pop   (qb_pop),
        .o_tick  (qb_tick)
    );

    rpsc_back #(
        .MOTOR_COUNT (MOTOR_COUNT)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (qb_valid),
        .o_pop    (qb_pop),
        .i_tick   (qb_tick),
        .o_valid  (m_tvalid),
        .i_ready  (m_tready),
        .o_motor  (res_motor),
        .o_duty   (res_duty),
        .o_target (res_target),
        .o_error  (res_error),
        .o_fault  (res_fault)
    );

    assign m_tdata = {{(M_TDATA_W - OUT_FIELDS_W){1'b0}},
                      res_fault, res_error, res_target, res_duty, res_motor};

endmodule

// ----- bench/tb_ramped_pi_motor_speed_controller.sv -----
// ----------------------------------------------------------------------------
// tb_ramped_pi_motor_speed_controller: self-checking bench of the PI speed loop
// A queue-fed driver sends control ticks over the input stream and a monitor
// compares every output transfer against a built-in model of the per-motor
// ramp, integral, duty decision and shared fault counter. Directed ticks run
// first, then random phases under changing settings and handshake idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_ramped_pi_motor_speed_controller;

    import rpsc_pkg::*;

    localparam int MOTORS = 8;

    typedef struct packed {
        logic               clear;
        logic [DUTY_W-1:0]  offset;
        logic [RPM_W-1:0]   meas_rpm;
        logic [RPM_W-1:0]   set_rpm;
        logic               run;
        logic [MOTOR_W-1:0] motor;
    } t_tb_tick;

    typedef struct packed {
        logic [MOTOR_W-1:0] motor;
        logic [DUTY_W-1:0]  duty;
        logic [VAL_W-1:0]   target;
        logic [VAL_W-1:0]   error;
        logic               fault;
    } t_speed_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    ramped_pi_motor_speed_controller DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // settings as the block should hold them
    logic [GAIN_W-1:0]  prop_gain_r   = PROP_GAIN_RST;
    logic [GAIN_W-1:0]  integ_gain_r  = INTEG_GAIN_RST;
    logic [STEP_W-1:0]  ramp_step_r   = RAMP_STEP_RST;
    logic [DUTY_W-1:0]  max_duty_r    = MAX_DUTY_RST;
    logic [LEVEL_W-1:0] fault_level_r = FAULT_LEVEL_RST;
    logic [LIMIT_W-1:0] fault_limit_r = FAULT_LIMIT_RST;

    // per-motor loop state and the shared fault counter
    int                target_mem [MOTORS];
    int                integ_mem  [MOTORS];
    logic [DUTY_W-1:0] duty_mem   [MOTORS];
    logic [7:0]        bad_ticks  = '0;
    logic              fault_seen = 1'b0;

    t_tb_tick      tick_pending_q [$];
    t_speed_result duty_expect_q  [$];
    t_tb_tick      tick_on_bus;
    int            ticks_queued   = 0;
    int            ticks_accepted = 0;
    int            mismatches     = 0;
    int            send_idle_pct  = 0;
    int            recv_stall_pct = 0;
    int            rx_hold_len    = 0;
    logic [RPM_W-1:0] set_goal [MOTORS];

    function automatic int clamp16(int v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic int clamp32(longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return int'(v);
    endfunction

    function automatic t_speed_result predict_speed_loop(t_tb_tick t);
        t_speed_result r;
        int     tgt, err, mag, setv, measv, stepv, lvl;
        longint sum, kp, ki, off, mx;
        setv  = int'(t.set_rpm);
        measv = int'(t.meas_rpm);
        stepv = int'(ramp_step_r);
        lvl   = int'(fault_level_r);
        kp    = longint'(prop_gain_r);
        ki    = longint'(integ_gain_r);
        off   = longint'(t.offset);
        mx    = longint'(max_duty_r);
        r.motor = t.motor;
        if (t.clear) begin
            target_mem[t.motor] = 0;
            integ_mem[t.motor]  = 0;
            r.duty   = duty_mem[t.motor];
            r.target = '0;
            r.error  = '0;
            r.fault  = fault_seen;
            return r;
        end
        tgt = target_mem[t.motor];
        if (t.run) begin
            // two sequential tests: the second sees the stepped-up target
            if (tgt <= setv) tgt = clamp16(tgt + stepv);
            if (tgt > setv) tgt = clamp16(tgt - stepv);
        end else if (tgt > 0) begin
            tgt = clamp16(tgt - stepv);
        end
        target_mem[t.motor] = tgt;
        err = clamp16(tgt - measv);
        mag = (err < 0) ? -err : err;
        if (mag >= lvl) begin
            bad_ticks = bad_ticks + 8'd1;
            if (bad_ticks >= fault_limit_r) begin
                fault_seen = 1'b1;
                bad_ticks  = '0;
            end
        end
        integ_mem[t.motor] = clamp32(longint'(integ_mem[t.motor]) + longint'(err));
        sum = kp * longint'(err) + ki * longint'(integ_mem[t.motor]) + off;
        if (sum <= off) begin
            duty_mem[t.motor] = t.offset;
        end else if (sum <= mx) begin
            duty_mem[t.motor] = sum[DUTY_W-1:0];
        end
        r.duty   = duty_mem[t.motor];
        r.target = tgt[VAL_W-1:0];
        r.error  = err[VAL_W-1:0];
        r.fault  = fault_seen;
        return r;
    endfunction

    // input side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                duty_expect_q.push_back(predict_speed_loop(tick_on_bus));
                ticks_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (tick_pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    tick_on_bus = tick_pending_q.pop_front();
                    s_tdata  <= {tick_on_bus.offset, tick_on_bus.meas_rpm,
                                 tick_on_bus.set_rpm, tick_on_bus.run, tick_on_bus.motor};
                    s_tuser  <= tick_on_bus.clear;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(string label, int want_v, int got_v);
        if (want_v != got_v) begin
            $display("%0t: %s expected %0d, actual %0d", $time, label, want_v, got_v);
            mismatches++;
        end
    endtask

    // output side
    always @(posedge i_clk) begin : result_side
        t_speed_result got, want;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.motor  = m_tdata[2:0];
                got.duty   = m_tdata[18:3];
                got.target = m_tdata[34:19];
                got.error  = m_tdata[50:35];
                got.fault  = m_tdata[51];
                if (duty_expect_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, got);
                    mismatches++;
                end else begin
                    want = duty_expect_q.pop_front();
                    check_field("motor", int'(want.motor), int'(got.motor));
                    check_field("duty", int'(want.duty), int'(got.duty));
                    check_field("ramp_target", int'($signed(want.target)),
                                int'($signed(got.target)));
                    check_field("speed_error", int'($signed(want.error)),
                                int'($signed(got.error)));
                    check_field("fault", int'(want.fault), int'(got.fault));
                end
            end
            if (rx_hold_len > 0) begin
                m_tready <= 1'b0;
                rx_hold_len--;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic queue_tick(int motor, int run, int set_v, int meas, int off, int clr);
        t_tb_tick t;
        t.motor    = MOTOR_W'(motor);
        t.run      = 1'(run);
        t.set_rpm  = RPM_W'(set_v);
        t.meas_rpm = RPM_W'(meas);
        t.offset   = DUTY_W'(off);
        t.clear    = 1'(clr);
        tick_pending_q.push_back(t);
        ticks_queued++;
    endtask

    task automatic wait_drained();
        while (ticks_accepted != ticks_queued || duty_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        case (idx)
            REG_PROP_GAIN:   prop_gain_r   = val[GAIN_W-1:0];
            REG_INTEG_GAIN:  integ_gain_r  = val[GAIN_W-1:0];
            REG_RAMP_STEP:   ramp_step_r   = val[STEP_W-1:0];
            REG_MAX_DUTY:    max_duty_r    = val[DUTY_W-1:0];
            REG_FAULT_LEVEL: fault_level_r = val[LEVEL_W-1:0];
            REG_FAULT_LIMIT: fault_limit_r = val[LIMIT_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // called right after a rising edge with the block idle
    task automatic apply_settings(int kp, int ki, int step, int mx, int lvl, int lim);
        write_reg(REG_PROP_GAIN, CFG_DATA_W'(kp));
        write_reg(REG_INTEG_GAIN, CFG_DATA_W'(ki));
        write_reg(REG_RAMP_STEP, CFG_DATA_W'(step));
        write_reg(REG_MAX_DUTY, CFG_DATA_W'(mx));
        write_reg(REG_FAULT_LEVEL, CFG_DATA_W'(lvl));
        write_reg(REG_FAULT_LIMIT, CFG_DATA_W'(lim));
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic queue_random_tick();
        int m, r, meas, off, pick;
        m = $urandom_range(MOTORS - 1);
        r = $urandom_range(99);
        if ($urandom_range(99) < 8) begin
            pick = $urandom_range(9);
            if (pick == 0) set_goal[m] = '0;
            else if (pick == 1) set_goal[m] = '1;
            else set_goal[m] = RPM_W'($urandom_range(3000));
        end
        pick = $urandom_range(9);
        if (pick == 0) off = int'($urandom_range(65535));
        else if (pick == 1) off = 65535;
        else off = int'($urandom_range(2000));
        if (r < 5) begin
            queue_tick(m, $urandom_range(1), $urandom_range(16383), $urandom_range(16383),
                       $urandom_range(65535), 1);
        end else if (r < 15) begin
            queue_tick($urandom_range(MOTORS - 1), $urandom_range(1), $urandom_range(16383),
                       $urandom_range(16383), $urandom_range(65535), 0);
        end else if (r < 25) begin
            queue_tick(m, 0, $urandom_range(16383), $urandom_range(1500), off, 0);
        end else begin
            // steady run toward this motor's goal, encoder near the goal
            meas = int'(set_goal[m]) + int'($urandom_range(600)) - 300;
            if (meas < 0) meas = 0;
            if (meas > 16383) meas = 16383;
            queue_tick(m, 1, int'(set_goal[m]), meas, off, 0);
        end
    endtask

    task automatic random_phase(int count, int snd_idle, int rcv_stall, int long_hold);
        send_idle_pct  = snd_idle;
        recv_stall_pct = rcv_stall;
        rx_hold_len    = long_hold;
        repeat (count / 2) queue_random_tick();
        // sender stops until every result of the first half is back
        wait_drained();
        repeat (count - count / 2) queue_random_tick();
        wait_drained();
    endtask

    initial begin
        for (int i = 0; i < MOTORS; i++) begin
            target_mem[i] = 0;
            integ_mem[i]  = 0;
            duty_mem[i]   = '0;
            set_goal[i]   = RPM_W'($urandom_range(3000));
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: ramp steps both ways, floor, stop at zero, clear
        queue_tick(0, 1, 100, 0, 0, 0);
        queue_tick(0, 1, 100, 0, 0, 0);
        queue_tick(0, 1, 7, 0, 0, 0);
        queue_tick(0, 1, 5, 5, 0, 0);
        queue_tick(1, 0, 0, 300, 1000, 0);
        queue_tick(2, 1, 16383, 16383, 65535, 0);
        queue_tick(2, 0, 16383, 16383, 65535, 1);
        queue_tick(3, 1, 0, 0, 0, 0);
        queue_tick(3, 0, 0, 0, 0, 0);
        queue_tick(4, 1, 3, 0, 0, 0);
        queue_tick(5, 1, 4000, 0, 100, 0);
        queue_tick(6, 1, 16383, 16383, 65535, 1);
        wait_drained();

        // largest settings: duty held above max, target driven below zero
        apply_settings(255, 255, 1023, 65535, 16383, 255);
        queue_tick(7, 1, 16383, 0, 0, 0);
        queue_tick(7, 1, 16383, 0, 0, 0);
        queue_tick(7, 1, 16383, 0, 65535, 0);
        queue_tick(7, 0, 0, 0, 0, 0);
        queue_tick(7, 0, 0, 16383, 0, 0);
        queue_tick(7, 0, 0, 0, 500, 0);
        queue_tick(7, 0, 0, 0, 0, 0);
        queue_tick(7, 1, 0, 0, 0, 0);
        queue_tick(5, 1, 0, 16383, 65535, 0);
        queue_tick(7, 1, 0, 0, 0, 1);
        queue_tick(0, 0, 16383, 16383, 0, 0);
        queue_tick(4, 1, 16383, 0, 0, 0);
        wait_drained();

        apply_settings($urandom_range(16), $urandom_range(2), $urandom_range(1, 200),
                       $urandom_range(1000, 65535), $urandom_range(1500, 16383),
                       $urandom_range(150, 255));
        random_phase(300, 0, 0, 200);
        apply_settings($urandom_range(255), $urandom_range(1), $urandom_range(1, 1023),
                       $urandom_range(65535), $urandom_range(1500, 16383),
                       $urandom_range(150, 255));
        random_phase(250, 72, 0, 0);
        apply_settings($urandom_range(16), $urandom_range(3), $urandom_range(1, 100),
                       $urandom_range(1000, 65535), $urandom_range(1500, 16383),
                       $urandom_range(150, 255));
        random_phase(250, 0, 72, 0);
        apply_settings(0, 0, 0, 0, 16383, 1);
        random_phase(250, 13, 13, 0);
        // every non-clear tick counts as bad here, so the fault latches
        apply_settings($urandom_range(8), $urandom_range(2), $urandom_range(1, 200),
                       $urandom_range(1000, 65535), 0, $urandom_range(1, 40));
        random_phase(250, 13, 13, 0);

        if (duty_expect_q.size() != 0) begin
            $display("%0t: pending results expected 0, actual %0d", $time,
                     duty_expect_q.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/rpsc_pkg.sv
rtl/core/rpsc_front.sv
rtl/core/rpsc_queue.sv
rtl/core/rpsc_back.sv
rtl/core/ramped_pi_motor_speed_controller.sv
bench/tb_ramped_pi_motor_speed_controller.sv
